@@ design/lkvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// Holds the request and result records passed between the core and the table.
// Depends on nothing.
package lkvc_pkg;

  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CapW = 5;

  localparam logic [CapW-1:0] CapReset  = 5'd16;
  localparam logic [ValW-1:0] MissValue = 32'hFFFF_FFFF;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  typedef struct packed {
    action_t         action;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] read_value;
    logic            evicted;
    logic [KeyW-1:0] evicted_key;
  } res_t;

endpackage

@@ design/lkvc_table.sv @@
// Entry table of the LRU key-value cache: keys, values, valid bits, recency
// ranks and used count, with the combinational lookup and registered update logic.
// Depends on lkvc_pkg.
module lkvc_table #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lkvc_pkg::CapW-1:0]   cfg_capacity,
  input  logic                        req_go,
  input  lkvc_pkg::req_t              req,
  output lkvc_pkg::res_t              res
);
  import lkvc_pkg::*;

  localparam int AgeW = $clog2(ENTRIES);
  localparam int UseW = $clog2(ENTRIES + 1);
  localparam int CmpW = (UseW > CapW) ? UseW : CapW;

  logic [CapW-1:0]    capacity_r;
  logic [KeyW-1:0]    key_r   [ENTRIES];
  logic [ValW-1:0]    value_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [AgeW-1:0]    age_r   [ENTRIES];
  logic [UseW-1:0]    used_r;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] fill_sel;
  logic [ENTRIES-1:0] sel;
  logic               found;
  logic [AgeW-1:0]    hit_age;
  logic [ValW-1:0]    hit_value;
  logic [KeyW-1:0]    victim_key;
  logic [AgeW-1:0]    oldest_age;
  logic [AgeW-1:0]    rank;
  logic [CapW-1:0]    cap_eff;
  logic               full;
  logic               is_put;
  logic               do_evict;
  logic               do_fill;
  logic               do_promote;

  // Parallel key compare and one-hot reads of the matching and oldest entries.
  always_comb begin
    hit_age    = '0;
    hit_value  = '0;
    victim_key = '0;
    oldest_age = AgeW'(used_r - UseW'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == req.key);
      victim[i] = valid_r[i] && (age_r[i] == oldest_age);
      hit_age    = hit_age    | (match[i]  ? age_r[i]   : '0);
      hit_value  = hit_value  | (match[i]  ? value_r[i] : '0);
      victim_key = victim_key | (victim[i] ? key_r[i]   : '0);
    end
    found = |match;
  end

  // Lowest free slot, effective capacity and the kind of update.
  always_comb begin
    fill_sel   = ~valid_r & (valid_r + ENTRIES'(1));
    cap_eff    = (capacity_r == '0) ? CapW'(1) : capacity_r;
    full       = (CmpW'(used_r) >= CmpW'(cap_eff)) || (used_r == UseW'(ENTRIES));
    is_put     = (req.action == ACT_PUT);
    do_evict   = is_put && !found && full;
    do_fill    = is_put && !found && !full;
    do_promote = found || do_evict;
    rank       = found ? hit_age : oldest_age;
    if (found) begin
      sel = match;
    end else if (do_evict) begin
      sel = victim;
    end else if (do_fill) begin
      sel = fill_sel;
    end else begin
      sel = '0;
    end
  end

  // Result of the current request.
  always_comb begin
    res.hit         = found;
    res.read_value  = is_put ? '0 : (found ? hit_value : MissValue);
    res.evicted     = do_evict;
    res.evicted_key = do_evict ? victim_key : '0;
  end

  // Control state: capacity, valid bits, ranks and used count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CapReset;
      valid_r    <= '0;
      used_r     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_capacity;
      end
      if (req_go) begin
        if (do_fill) begin
          valid_r <= valid_r | fill_sel;
          used_r  <= used_r + UseW'(1);
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (sel[i]) begin
            age_r[i] <= '0;
          end else if (valid_r[i] && (do_fill || (do_promote && (age_r[i] < rank)))) begin
            age_r[i] <= age_r[i] + AgeW'(1);
          end
        end
      end
    end
  end

  // Payload storage: written on any put that selects the slot.
  always_ff @(posedge clk) begin
    if (req_go && is_put) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i]) begin
          key_r[i]   <= req.key;
          value_r[i] <= req.value;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("more than one valid entry matches the key");

  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(used_r))
    else $error("used count disagrees with the valid bits");

  a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (req_go && do_evict) |-> $onehot(victim))
    else $error("eviction without exactly one oldest entry");

  a_fill_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (req_go && do_fill) |-> $onehot(fill_sel))
    else $error("fill without a free slot");

  a_fill_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (req_go && do_fill) |=> (used_r == $past(used_r) + UseW'(1)))
    else $error("fill did not advance the used count");
`endif

endmodule

@@ design/lru_key_value_cache_core.sv @@
// LRU key-value cache core: a request goes from its input transfer into the input register,
// then through the table lookup and update into the result register.
// Throughput is one item per cycle unless out_tready stalls it; one table update per request.
// The result register has its own valid, so a new item is taken while a result waits.
// Synchronous active-low reset clears valid bits, ranks, used count and sets
// capacity to 16; keys and values are not cleared. Depends on lkvc_pkg, lkvc_table.
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration write: capacity.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lkvc_pkg::CapW-1:0] cfg_data,
  // Request stream.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // key[31:0], value[63:32]
  input  logic [0:0]                in_tuser,   // action[0]
  // Result stream.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [63:0]               out_tdata,  // read_value[31:0], evicted_key[63:32]
  output logic [1:0]                out_tuser   // hit[0], evicted[1]
);
  import lkvc_pkg::*;

  logic  s0_valid_r;
  req_t  s0_req_r;
  logic  out_valid_r;
  res_t  out_res_r;
  res_t  res;
  logic  go;

  assign cfg_ready = 1'b1;

  // The request in the input register moves on when the result register is free.
  assign go        = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || go;

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s0_req_r.action <= action_t'(in_tuser[0]);
      s0_req_r.key    <= in_tdata[31:0];
      s0_req_r.value  <= in_tdata[63:32];
    end
  end

  lkvc_table #(
    .ENTRIES(ENTRIES)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (cfg_data),
    .req_go       (go),
    .req          (s0_req_r),
    .res          (res)
  );

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (go) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.evicted_key, out_res_r.read_value};
  assign out_tuser  = {out_res_r.evicted, out_res_r.hit};

endmodule
